FILE: rtl/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants for the LRU cache with access cost accounting.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int SIZE_W  = 6;
    localparam int COST_W  = 3;
    localparam int TOTAL_W = 32;

    localparam logic [COST_W-1:0]  HIT_COST  = 3'd1;
    localparam logic [COST_W-1:0]  MISS_COST = 3'd5;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_FILL,
        UPD_REPL
    } t_upd_op;

    typedef struct packed {
        logic    cmp;
        t_upd_op op;
    } t_cell_ctl;

endpackage

FILE: rtl/lruc_cell.sv
// ----------------------------------------------------------------------------
// lruc_cell
// One cache entry: tag, valid bit and recency rank, with its own tag compare.
// Hit flag and hit rank are passed along the chain to the next cell.
// ----------------------------------------------------------------------------
module lruc_cell
    import lruc_pkg::*;
#(
    parameter int KEY_BITS = 64,
    parameter int RW       = 5,
    parameter int CW       = 6,
    parameter int IDX      = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [RW-1:0]       i_limit,
    input  logic [CW-1:0]       i_vc,
    input  logic                i_hit_acc,
    input  logic [RW-1:0]       i_rank_acc,
    output logic                o_hit_acc,
    output logic [RW-1:0]       o_rank_acc
);

    logic [KEY_BITS-1:0] r_tag;
    logic                r_valid;
    logic [RW-1:0]       r_rank;
    logic                r_match;

    logic                n_valid;
    logic [RW-1:0]       n_rank;
    logic                load_tag;
    logic                is_free_slot;

    assign is_free_slot = (i_vc == CW'(IDX));

    always_comb begin
        n_valid  = r_valid;
        n_rank   = r_rank;
        load_tag = 1'b0;
        case (i_ctl.op)
            UPD_HIT: begin
                if (r_match) begin
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_limit)) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            UPD_FILL: begin
                if (is_free_slot) begin
                    n_valid  = 1'b1;
                    n_rank   = '0;
                    load_tag = 1'b1;
                end else if (r_valid) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            UPD_REPL: begin
                if (r_valid && (r_rank == i_limit)) begin
                    n_rank   = '0;
                    load_tag = 1'b1;
                end else if (r_valid && (r_rank < i_limit)) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            if (i_ctl.cmp) begin
                r_match <= r_valid && (r_tag == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_tag) begin
            r_tag <= i_key;
        end
    end

    assign o_hit_acc  = i_hit_acc | r_match;
    assign o_rank_acc = i_rank_acc | (r_match ? r_rank : '0);

endmodule

FILE: rtl/lru_cache_hit_cost_top.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_top
// Fully associative LRU cache as a row of entry cells, with hit/miss cost
// and a saturating running total of costs.
//
//   channel   dir  handshake             payload
//   s         in   i_s_tvalid/o_s_tready i_s_tdata: key_tag
//   m         out  o_m_tvalid/i_m_tready o_m_tdata: cost, total_cost; tuser: hit
//   cfg       in   i_cfg_we              i_cfg_wdata: cache_size
//
// Each transaction passes through accept, tag compare in every cell, then
// rank/tag update, driven on a hit by the hit rank collected along the cell chain.
// A new key is accepted while the previous result waits in the output register.
// The update cycle stalls while the output register holds an untaken result.
// Reset clears all valid bits, ranks, the fill count and the total at once.
// ----------------------------------------------------------------------------
module lru_cache_hit_cost_top
    import lruc_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int KEY_BITS    = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [63:0]       i_s_tdata,   // key_tag
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // cost [2:0], total_cost [34:3], zero pad
    output logic [0:0]        o_m_tuser,   // hit
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata  // cache_size
);

    localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [KEY_BITS-1:0] r_key;
    logic [CW-1:0]       r_vc;
    logic [TOTAL_W-1:0]  r_total;
    logic                r_out_valid;
    logic                r_out_hit;
    logic [COST_W-1:0]   r_out_cost;

    t_cell_ctl           cell_ctl;
    t_upd_op             upd_op;
    logic                upd_go;
    logic                s_accept;
    logic                hit;
    logic [RW-1:0]       limit;
    logic [COST_W-1:0]   cost;
    logic [TOTAL_W:0]    total_sum;
    logic                vc_lt_size;
    logic                vc_lt_max;

    logic                hit_chain  [MAX_ENTRIES+1];
    logic [RW-1:0]       rank_chain [MAX_ENTRIES+1];

    assign hit_chain[0]  = 1'b0;
    assign rank_chain[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lruc_cell #(
            .KEY_BITS (KEY_BITS),
            .RW       (RW),
            .CW       (CW),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_key      (r_key),
            .i_limit    (limit),
            .i_vc       (r_vc),
            .i_hit_acc  (hit_chain[g]),
            .i_rank_acc (rank_chain[g]),
            .o_hit_acc  (hit_chain[g+1]),
            .o_rank_acc (rank_chain[g+1])
        );
    end

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign upd_go     = (r_state == S_UPD) && (!r_out_valid || i_m_tready);
    assign hit        = (r_size != '0) && hit_chain[MAX_ENTRIES];
    assign vc_lt_size = CMPW'(r_vc) < CMPW'(r_size);
    assign vc_lt_max  = r_vc < CW'(MAX_ENTRIES);
    assign cost       = hit ? HIT_COST : MISS_COST;
    assign total_sum  = {1'b0, r_total} + (TOTAL_W+1)'(cost);

    always_comb begin
        if (r_size == '0) begin
            upd_op = UPD_NONE;
        end else if (hit) begin
            upd_op = UPD_HIT;
        end else if (vc_lt_size && vc_lt_max) begin
            upd_op = UPD_FILL;
        end else begin
            upd_op = UPD_REPL;
        end
    end

    always_comb begin
        if (upd_op == UPD_HIT) begin
            limit = rank_chain[MAX_ENTRIES];
        end else begin
            limit = RW'(r_vc - 1'b1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready   = 1'b0;
        cell_ctl.cmp = 1'b0;
        cell_ctl.op  = UPD_NONE;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_CMP: begin
                cell_ctl.cmp = 1'b1;
            end
            S_UPD: begin
                if (upd_go) begin
                    cell_ctl.op = upd_op;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_vc        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (upd_go && (upd_op == UPD_FILL)) begin
                r_vc <= r_vc + 1'b1;
            end
            if (upd_go) begin
                r_total     <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key <= i_s_tdata[KEY_BITS-1:0];
        end
        if (upd_go) begin
            r_out_hit  <= hit;
            r_out_cost <= cost;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_total, r_out_cost};
    assign o_m_tuser  = r_out_hit;

    a_vc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc <= CW'(MAX_ENTRIES))
        else $error("fill count above entry count");

    a_vc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc != $past(r_vc)) |-> (r_vc == $past(r_vc) + 1'b1))
        else $error("fill count moved by other than one");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_CMP))
        else $error("accepted transaction did not enter compare");

    a_upd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_out_valid && !i_m_tready) |=> (r_state == S_UPD))
        else $error("update ran over an untaken result");

    a_cost_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] ? (o_m_tdata[2:0] == HIT_COST)
                                     : (o_m_tdata[2:0] == MISS_COST)))
        else $error("cost does not match hit flag");

endmodule
